@@ hdl/qvr_pkg.sv @@
// Shared widths, command code and interface structs for the quaternion
// vector rotation datapath. No dependencies.
package qvr_pkg;

    localparam int VW     = 32;               // vector component width
    localparam int QW     = 32;               // quaternion component width
    localparam int PROD_W = 2 * QW;           // one quaternion product
    localparam int DN_W   = 2 * QW + 1;       // |q|^2
    localparam int ME_W   = 2 * QW + 3;       // matrix entry, signed
    localparam int LO_W   = ME_W / 2;         // low slice of an entry
    localparam int HI_W   = ME_W - LO_W;      // high slice of an entry
    localparam int PL_W   = LO_W + VW + 1;    // low partial product
    localparam int PH_W   = HI_W + VW;        // high partial product
    localparam int ACC_W  = ME_W + VW;        // dot product, signed
    localparam int N_W    = ACC_W + 1;        // 2|acc| + d
    localparam int D_W    = DN_W + 1;         // 2d
    localparam int REM_W  = N_W - VW;         // divider remainder

    localparam logic CMD_TO_BODY = 1'b1;      // transpose

    typedef struct packed {
        logic signed [ME_W-1:0] e0;
        logic signed [ME_W-1:0] e1;
        logic signed [ME_W-1:0] e2;
    } t_row;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic [DN_W-1:0]        d;
        logic signed [VW-1:0]   vx;
        logic signed [VW-1:0]   vy;
        logic signed [VW-1:0]   vz;
    } t_ctl;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic                   sat;
        logic [VW-1:0]          rot;
    } t_res;

endpackage

@@ hdl/qvr_matrix.sv @@
// Quaternion products and rotation matrix build, two register stages.
// Depends on qvr_pkg.
module qvr_matrix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic                         i_command,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_x,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_y,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_z,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_w,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_x,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_y,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_z,
    output qvr_pkg::t_ctl                o_ctl,
    output qvr_pkg::t_row                o_row0,
    output qvr_pkg::t_row                o_row1,
    output qvr_pkg::t_row                o_row2
);
    logic signed [qvr_pkg::PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz,
                                       r_wx, r_wy, r_wz;
    logic signed [qvr_pkg::VW-1:0]     r_vx, r_vy, r_vz;
    logic                              r_cmd, r_vld;

    logic signed [qvr_pkg::ME_W-1:0]   ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [qvr_pkg::ME_W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [qvr_pkg::ME_W-1:0]   dsum;
    qvr_pkg::t_ctl                     n_ctl, r_ctl;
    qvr_pkg::t_row                     n_row0, n_row1, n_row2, r_row0, r_row1, r_row2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_vld       <= i_valid;
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_en) begin
            r_ww <= i_quat_w * i_quat_w;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_wy <= i_quat_w * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_vx <= i_vec_x;
            r_vy <= i_vec_y;
            r_vz <= i_vec_z;
            r_cmd <= i_command;
            r_ctl.zero <= n_ctl.zero;
            r_ctl.d    <= n_ctl.d;
            r_ctl.vx   <= n_ctl.vx;
            r_ctl.vy   <= n_ctl.vy;
            r_ctl.vz   <= n_ctl.vz;
            r_row0 <= n_row0;
            r_row1 <= n_row1;
            r_row2 <= n_row2;
        end
    end

    always_comb begin
        ww = qvr_pkg::ME_W'(r_ww);
        xx = qvr_pkg::ME_W'(r_xx);
        yy = qvr_pkg::ME_W'(r_yy);
        zz = qvr_pkg::ME_W'(r_zz);
        xy = qvr_pkg::ME_W'(r_xy);
        xz = qvr_pkg::ME_W'(r_xz);
        yz = qvr_pkg::ME_W'(r_yz);
        wx = qvr_pkg::ME_W'(r_wx);
        wy = qvr_pkg::ME_W'(r_wy);
        wz = qvr_pkg::ME_W'(r_wz);
        m00 = ww + xx - yy - zz;
        m11 = ww - xx + yy - zz;
        m22 = ww - xx - yy + zz;
        m01 = (xy - wz) <<< 1;
        m10 = (xy + wz) <<< 1;
        m02 = (xz + wy) <<< 1;
        m20 = (xz - wy) <<< 1;
        m12 = (yz - wx) <<< 1;
        m21 = (yz + wx) <<< 1;
        dsum = ww + xx + yy + zz;
        n_ctl.valid = r_vld;
        n_ctl.d     = dsum[qvr_pkg::DN_W-1:0];
        n_ctl.zero  = (dsum == '0);
        n_ctl.vx    = r_vx;
        n_ctl.vy    = r_vy;
        n_ctl.vz    = r_vz;
        if (r_cmd == qvr_pkg::CMD_TO_BODY) begin
            n_row0 = '{e0: m00, e1: m10, e2: m20};
            n_row1 = '{e0: m01, e1: m11, e2: m21};
            n_row2 = '{e0: m02, e1: m12, e2: m22};
        end else begin
            n_row0 = '{e0: m00, e1: m01, e2: m02};
            n_row1 = '{e0: m10, e1: m11, e2: m12};
            n_row2 = '{e0: m20, e1: m21, e2: m22};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_row0 = r_row0;
    assign o_row1 = r_row1;
    assign o_row2 = r_row2;

endmodule

@@ hdl/qvr_lane.sv @@
// One output component: dot product of a matrix row with v, then a
// one-bit-per-stage rounding divider by |q|^2 and saturation. Uses qvr_pkg.
module qvr_lane (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  qvr_pkg::t_ctl i_ctl,
    input  qvr_pkg::t_row i_row,
    output qvr_pkg::t_res o_res
);
    localparam int NS = qvr_pkg::VW;

    // partial products
    logic signed [qvr_pkg::PL_W-1:0]  r_pl [3];
    logic signed [qvr_pkg::PH_W-1:0]  r_ph [3];
    logic [qvr_pkg::DN_W-1:0]         r3_d, r4_d;
    logic                             r3_zero, r4_zero, r3_vld, r4_vld;
    logic signed [qvr_pkg::ACC_W-1:0] r_acc;

    // divider stages
    logic [qvr_pkg::REM_W-1:0] r_rem  [NS+1];
    logic [NS-1:0]             r_nlo  [NS+1];
    logic [NS-1:0]             r_q    [NS+1];
    logic [qvr_pkg::D_W-1:0]   r_den  [NS+1];
    logic                      r_neg  [NS+1];
    logic                      r_big  [NS+1];
    logic                      r_zero [NS+1];
    logic                      r_vld  [NS+1];

    logic signed [qvr_pkg::VW-1:0]    v   [3];
    logic signed [qvr_pkg::ME_W-1:0]  e   [3];
    logic signed [qvr_pkg::ACC_W-1:0] n_acc;
    logic [qvr_pkg::ACC_W-1:0]        mag;
    logic [qvr_pkg::N_W-1:0]          num, lim_n;
    logic [qvr_pkg::D_W-1:0]          den;
    logic                             neg;
    logic [qvr_pkg::REM_W-1:0]        t    [NS];
    logic                             ge   [NS];
    logic [NS-1:0]                    lim, qmag;
    logic                             sat;
    qvr_pkg::t_res                    n_res, r_res;

    always_comb begin
        v[0] = i_ctl.vx;
        v[1] = i_ctl.vy;
        v[2] = i_ctl.vz;
        e[0] = i_row.e0;
        e[1] = i_row.e1;
        e[2] = i_row.e2;

        n_acc = '0;
        for (int k = 0; k < 3; k++) begin
            n_acc = n_acc + {r_ph[k], {qvr_pkg::LO_W{1'b0}}}
                          + qvr_pkg::ACC_W'(r_pl[k]);
        end

        neg   = r_acc[qvr_pkg::ACC_W-1];
        mag   = neg ? qvr_pkg::ACC_W'(-r_acc) : qvr_pkg::ACC_W'(r_acc);
        num   = {mag, 1'b0} + qvr_pkg::N_W'(r4_d);
        den   = {r4_d, 1'b0};
        lim_n = qvr_pkg::N_W'({den, {NS{1'b0}}});

        for (int j = 0; j < NS; j++) begin
            t[j]  = {r_rem[j][qvr_pkg::REM_W-2:0], r_nlo[j][NS-1]};
            ge[j] = (t[j] >= qvr_pkg::REM_W'(r_den[j]));
        end

        lim  = r_neg[NS] ? {1'b1, {(NS-1){1'b0}}} : {1'b0, {(NS-1){1'b1}}};
        sat  = r_big[NS] || (r_q[NS] > lim);
        qmag = sat ? lim : r_q[NS];
        n_res.valid = r_vld[NS];
        n_res.zero  = r_zero[NS];
        n_res.sat   = sat;
        n_res.rot   = r_neg[NS] ? -qmag : qmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            for (int j = 0; j <= NS; j++) r_vld[j] <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r3_vld   <= i_ctl.valid;
            r4_vld   <= r3_vld;
            r_vld[0] <= r4_vld;
            for (int j = 1; j <= NS; j++) r_vld[j] <= r_vld[j-1];
            r_res.valid <= n_res.valid;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= $signed({1'b0, e[k][qvr_pkg::LO_W-1:0]}) * v[k];
                r_ph[k] <= $signed(e[k][qvr_pkg::ME_W-1:qvr_pkg::LO_W]) * v[k];
            end
            r3_d    <= i_ctl.d;
            r3_zero <= i_ctl.zero;
            r_acc   <= n_acc;
            r4_d    <= r3_d;
            r4_zero <= r3_zero;

            r_rem[0]  <= num[qvr_pkg::N_W-1:NS];
            r_nlo[0]  <= num[NS-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= den;
            r_neg[0]  <= neg;
            r_big[0]  <= (num >= lim_n);
            r_zero[0] <= r4_zero;
            for (int j = 1; j <= NS; j++) begin
                r_rem[j]  <= ge[j-1] ? t[j-1] - qvr_pkg::REM_W'(r_den[j-1]) : t[j-1];
                r_nlo[j]  <= {r_nlo[j-1][NS-2:0], 1'b0};
                r_q[j]    <= {r_q[j-1][NS-2:0], ge[j-1]};
                r_den[j]  <= r_den[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_big[j]  <= r_big[j-1];
                r_zero[j] <= r_zero[j-1];
            end
            r_res.zero <= n_res.zero;
            r_res.sat  <= n_res.sat;
            r_res.rot  <= n_res.rot;
        end
    end

    assign o_res = r_res;

endmodule

@@ hdl/quaternion_vector_rotate_unit.sv @@
// Quaternion vector rotation, top level: matrix build, three component lanes,
// merge into the output word register. Uses qvr_pkg, qvr_matrix, qvr_lane.
// Pipeline: 39 register stages, set by the 32-stage per-lane divider (one
// quotient bit per stage) plus 7 other stages.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word is stalled. Reset (sync, active low) clears all valid bits.
module quaternion_vector_rotate_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_x,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_y,
    input  logic signed [qvr_pkg::VW-1:0] i_vec_z,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_w,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_x,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_y,
    input  logic signed [qvr_pkg::QW-1:0] i_quat_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [qvr_pkg::VW-1:0] o_rot_x,
    output logic signed [qvr_pkg::VW-1:0] o_rot_y,
    output logic signed [qvr_pkg::VW-1:0] o_rot_z,
    output logic                          o_saturated,
    output logic                          o_zero_quaternion
);
    logic          en;
    qvr_pkg::t_ctl ctl;
    qvr_pkg::t_row row0, row1, row2;
    qvr_pkg::t_res res0, res1, res2;

    logic                   r_vld, r_sat, r_zero;
    logic [qvr_pkg::VW-1:0] r_x, r_y, r_z;

    assign en         = !r_vld || i_out_ready;
    assign o_in_ready = en;

    qvr_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_command(i_command),
        .i_vec_x  (i_vec_x),
        .i_vec_y  (i_vec_y),
        .i_vec_z  (i_vec_z),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_ctl    (ctl),
        .o_row0   (row0),
        .o_row1   (row1),
        .o_row2   (row2)
    );

    qvr_lane u_lane0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                      .i_ctl(ctl), .i_row(row0), .o_res(res0));
    qvr_lane u_lane1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                      .i_ctl(ctl), .i_row(row1), .o_res(res1));
    qvr_lane u_lane2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                      .i_ctl(ctl), .i_row(row2), .o_res(res2));

    // merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= res0.valid;
        end
        if (en) begin
            r_zero <= res0.zero;
            r_sat  <= !res0.zero && (res0.sat || res1.sat || res2.sat);
            r_x    <= res0.zero ? '0 : res0.rot;
            r_y    <= res0.zero ? '0 : res1.rot;
            r_z    <= res0.zero ? '0 : res2.rot;
        end
    end

    assign o_out_valid       = r_vld;
    assign o_rot_x           = r_x;
    assign o_rot_y           = r_y;
    assign o_rot_z           = r_z;
    assign o_saturated       = r_sat;
    assign o_zero_quaternion = r_zero;

endmodule

@@ hdl/qvr_checker.sv @@
// Port-level checks for quaternion_vector_rotate_unit, bound to the top level.
// Uses qvr_pkg.
module qvr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [qvr_pkg::VW-1:0] o_rot_x,
    input logic signed [qvr_pkg::VW-1:0] o_rot_y,
    input logic signed [qvr_pkg::VW-1:0] o_rot_z,
    input logic                          o_saturated,
    input logic                          o_zero_quaternion
);
    localparam logic signed [qvr_pkg::VW-1:0] MAXV = {1'b0, {(qvr_pkg::VW-1){1'b1}}};
    localparam logic signed [qvr_pkg::VW-1:0] MINV = {1'b1, {(qvr_pkg::VW-1){1'b0}}};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_quaternion |->
            o_rot_x == '0 && o_rot_y == '0 && o_rot_z == '0 && !o_saturated)
        else $error("zero quaternion word not cleared");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_rot_x == MAXV || o_rot_x == MINV || o_rot_y == MAXV ||
            o_rot_y == MINV || o_rot_z == MAXV || o_rot_z == MINV)
        else $error("saturated flag without clipped component");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_rot_x) && $stable(o_rot_y) && $stable(o_rot_z))
        else $error("stalled output word changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_rot_x          (o_rot_x),
    .o_rot_y          (o_rot_y),
    .o_rot_z          (o_rot_z),
    .o_saturated      (o_saturated),
    .o_zero_quaternion(o_zero_quaternion)
);
